[hdl/tftp_rp_pkg.sv]
// ----------------------------------------------------------------------------
// tftp_rp_pkg
// shared types, codes and mode word tables for the tftp request parser
// ----------------------------------------------------------------------------
package tftp_rp_pkg;

	// parse phase, one-hot
	typedef enum logic [3:0] {
		PH_OPCODE = 4'b0001,
		PH_NAME   = 4'b0010,
		PH_MODE   = 4'b0100,
		PH_DONE   = 4'b1000
	} phase_t;

	typedef enum logic [2:0] {
		ERR_NONE     = 3'd0,
		ERR_TOO_LONG = 3'd1,
		ERR_NOT_REQ  = 3'd2,
		ERR_BAD_NAME = 3'd3,
		ERR_BAD_MODE = 3'd4
	} err_t;

	localparam logic [7:0] OP_READ  = 8'd1;
	localparam logic [7:0] OP_WRITE = 8'd2;

	localparam int OCTET_LEN    = 5;
	localparam int NETASCII_LEN = 8;
	// mode position saturates one past the longest mode word
	localparam logic [3:0] MODE_POS_MAX = 4'd9;

	localparam logic [7:0] OCTET_WORD [OCTET_LEN] = '{
		8'h6f, 8'h63, 8'h74, 8'h65, 8'h74
	};
	localparam logic [7:0] NETASCII_WORD [NETASCII_LEN] = '{
		8'h6e, 8'h65, 8'h74, 8'h61, 8'h73, 8'h63, 8'h69, 8'h69
	};

	typedef struct packed {
		logic       request_ok;
		logic       is_write;
		logic       transfer_mode;
		logic [9:0] name_length;
		err_t       error_kind;
	} result_t;

	// only ascii A-Z are folded
	function automatic logic [7:0] fold_case(input logic [7:0] b);
		logic [7:0] r;
		r = b;
		if (b >= 8'h41 && b <= 8'h5a) begin
			r = b + 8'h20;
		end
		return r;
	endfunction

endpackage

[hdl/tftp_request_parser_unit.sv]
// ----------------------------------------------------------------------------
// tftp_request_parser_unit
// parses a tftp read/write request arriving, unless in_stall holds it, one byte word per cycle
// ----------------------------------------------------------------------------
//  channel | handshake           | words
//  --------+---------------------+-------------------------------------------
//  input   | in_valid / in_stall | packet_byte, end_of_packet
//  output  | out_valid/out_stall | request_ok, is_write, transfer_mode,
//          |                     | name_length, error_kind
//
//  one byte word is taken per cycle while in_stall is low; the verdict for
//  a packet is built from the input register and held in the result register
//  the parse state is one register set updated by a single compare/count pass
//  reset clears all parse state; the block is ready right after reset
//  non-final bytes keep flowing while a verdict waits; only a final byte
//  stalls at the input register while the result register is still held
// ----------------------------------------------------------------------------
module tftp_request_parser_unit import tftp_rp_pkg::*; #(
	parameter int MAX_REQUEST_BYTES = 512
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] packet_byte,
	input  logic       end_of_packet,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       request_ok,
	output logic       is_write,
	output logic       transfer_mode,
	output logic [9:0] name_length,
	output logic [2:0] error_kind
);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	logic    out_free;
	logic    adv;
	logic    load;
	logic    in_take;
	result_t verdict;
	result_t result_q;

	// a byte moves on unless it is final and the result slot is taken
	assign adv      = valid_s1 && (!last_s1 || out_free);
	assign load     = adv && last_s1;
	assign in_stall = valid_s1 && !adv;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= packet_byte;
			last_s1 <= end_of_packet;
		end
	end

	tftp_rp_parse #(
		.MAX_REQUEST_BYTES(MAX_REQUEST_BYTES)
	) u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.byte_in(byte_s1),
		.last_in(last_s1),
		.result (verdict)
	);

	tftp_rp_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.result_in(verdict),
		.free     (out_free),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_q (result_q)
	);

	assign request_ok    = result_q.request_ok;
	assign is_write      = result_q.is_write;
	assign transfer_mode = result_q.transfer_mode;
	assign name_length   = result_q.name_length;
	assign error_kind    = result_q.error_kind;

	// a good verdict never carries an error code, a bad one always does
	a_ok_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (request_ok == (error_kind == ERR_NONE)))
		else $error("verdict flag and error code disagree");

	// rejected packets report no request details
	a_bad_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !request_ok) |-> (name_length == 10'd0 && !is_write && !transfer_mode))
		else $error("rejected packet carries request details");

	// a final byte waits while the previous verdict is held
	a_last_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && last_s1 && out_valid && out_stall) |-> in_stall)
		else $error("final byte overran a held verdict");

	// a loaded verdict is presented on the next cycle
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out_valid)
		else $error("verdict lost after load");

endmodule

[hdl/tftp_rp_parse.sv]
// ----------------------------------------------------------------------------
// tftp_rp_parse
// per-packet parse state and the verdict built on the last byte
// ----------------------------------------------------------------------------
module tftp_rp_parse import tftp_rp_pkg::*; #(
	parameter int MAX_REQUEST_BYTES = 512
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  logic [7:0] byte_in,
	input  logic       last_in,
	output result_t    result
);

	localparam int CW = $clog2(MAX_REQUEST_BYTES + 2);
	localparam logic [CW-1:0] LIMIT = CW'(MAX_REQUEST_BYTES + 1);
	localparam logic [CW-1:0] MAX_B = CW'(MAX_REQUEST_BYTES);

	logic [CW-1:0] byte_cnt_q, byte_cnt_nxt;
	logic [CW-1:0] fn_len_q, fn_len_nxt;
	logic [7:0]    op_high_q, op_high_nxt;
	logic          op_valid_q, op_valid_nxt;
	logic          op_write_q, op_write_nxt;
	phase_t        phase_q, phase_nxt;
	logic [3:0]    mode_pos_q, mode_pos_nxt;
	logic [1:0]    flags_q, flags_nxt;
	logic          too_long_q, too_long_nxt;
	logic [7:0]    c;
	logic [CW:0]   need;

	always_comb begin
		byte_cnt_nxt = byte_cnt_q;
		fn_len_nxt   = fn_len_q;
		op_high_nxt  = op_high_q;
		op_valid_nxt = op_valid_q;
		op_write_nxt = op_write_q;
		phase_nxt    = phase_q;
		mode_pos_nxt = mode_pos_q;
		flags_nxt    = flags_q;
		c            = fold_case(byte_in);

		case (phase_q)
			PH_OPCODE: begin
				if (byte_cnt_q == '0) begin
					op_high_nxt = byte_in;
				end else begin
					op_valid_nxt = (op_high_q == 8'd0) &&
						(byte_in == OP_READ || byte_in == OP_WRITE);
					op_write_nxt = (byte_in == OP_WRITE);
					phase_nxt    = PH_NAME;
				end
			end
			PH_NAME: begin
				if (byte_in == 8'd0) begin
					phase_nxt = PH_MODE;
				end else if (fn_len_q < LIMIT) begin
					fn_len_nxt = fn_len_q + 1'b1;
				end
			end
			PH_MODE: begin
				if (byte_in == 8'd0) begin
					phase_nxt = PH_DONE;
				end else begin
					if (mode_pos_q >= 4'(OCTET_LEN) || c != OCTET_WORD[mode_pos_q[2:0]]) begin
						flags_nxt[0] = 1'b0;
					end
					if (mode_pos_q >= 4'(NETASCII_LEN) ||
						c != NETASCII_WORD[mode_pos_q[2:0]]) begin
						flags_nxt[1] = 1'b0;
					end
					if (mode_pos_q < MODE_POS_MAX) begin
						mode_pos_nxt = mode_pos_q + 4'd1;
					end
				end
			end
			default: ;
		endcase

		if (byte_cnt_q < LIMIT) begin
			byte_cnt_nxt = byte_cnt_q + 1'b1;
		end
		too_long_nxt = too_long_q || (byte_cnt_nxt > MAX_B);
	end

	// verdict, taken on next-state values
	always_comb begin
		result = '{request_ok: 1'b0, is_write: 1'b0, transfer_mode: 1'b0,
			name_length: 10'd0, error_kind: ERR_NONE};
		need = {1'b0, fn_len_nxt} + (CW+1)'(5);
		if (too_long_nxt) begin
			result.error_kind = ERR_TOO_LONG;
		end else if (byte_cnt_nxt < CW'(2) || !op_valid_nxt) begin
			result.error_kind = ERR_NOT_REQ;
		end else if (phase_nxt == PH_OPCODE || phase_nxt == PH_NAME || fn_len_nxt == '0 ||
			{1'b0, byte_cnt_nxt} < need) begin
			result.error_kind = ERR_BAD_NAME;
		end else if (phase_nxt == PH_MODE) begin
			result.error_kind = ERR_BAD_MODE;
		end else if (flags_nxt[0] && mode_pos_nxt == 4'(OCTET_LEN)) begin
			result.request_ok  = 1'b1;
			result.is_write    = op_write_nxt;
			result.name_length = 10'(fn_len_nxt);
		end else if (flags_nxt[1] && mode_pos_nxt == 4'(NETASCII_LEN)) begin
			result.request_ok    = 1'b1;
			result.is_write      = op_write_nxt;
			result.transfer_mode = 1'b1;
			result.name_length   = 10'(fn_len_nxt);
		end else begin
			result.error_kind = ERR_BAD_MODE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_cnt_q <= '0;
			fn_len_q   <= '0;
			op_high_q  <= 8'd0;
			op_valid_q <= 1'b0;
			op_write_q <= 1'b0;
			phase_q    <= PH_OPCODE;
			mode_pos_q <= 4'd0;
			flags_q    <= 2'b11;
			too_long_q <= 1'b0;
		end else if (adv) begin
			if (last_in) begin
				byte_cnt_q <= '0;
				fn_len_q   <= '0;
				op_high_q  <= 8'd0;
				op_valid_q <= 1'b0;
				op_write_q <= 1'b0;
				phase_q    <= PH_OPCODE;
				mode_pos_q <= 4'd0;
				flags_q    <= 2'b11;
				too_long_q <= 1'b0;
			end else begin
				byte_cnt_q <= byte_cnt_nxt;
				fn_len_q   <= fn_len_nxt;
				op_high_q  <= op_high_nxt;
				op_valid_q <= op_valid_nxt;
				op_write_q <= op_write_nxt;
				phase_q    <= phase_nxt;
				mode_pos_q <= mode_pos_nxt;
				flags_q    <= flags_nxt;
				too_long_q <= too_long_nxt;
			end
		end
	end

endmodule

[hdl/tftp_rp_out.sv]
// ----------------------------------------------------------------------------
// tftp_rp_out
// result register with valid/stall handshake toward the consumer
// ----------------------------------------------------------------------------
module tftp_rp_out import tftp_rp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t result_in,
	output logic    free,
	output logic    out_valid,
	input  logic    out_stall,
	output result_t result_q
);

	logic valid_q;

	assign free      = !valid_q || !out_stall;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (free) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result_in;
		end
	end

endmodule

[dv/tftp_request_parser_unit_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tftp_request_parser_unit_test
// feeds tftp request packets byte word by byte word into the parser. A short
// directed list comes first, then random packets, with bursty input, a
// patterned output stall and one long output hold-off. A predictor tracks
// the parse and checks each verdict.
// ----------------------------------------------------------------------------
module tftp_request_parser_unit_test;
	import tftp_rp_pkg::*;

	localparam int MAX_BYTES       = 512;
	// counters saturate one past the size limit
	localparam int COUNT_SAT       = MAX_BYTES + 1;
	// byte words offered over the whole run, directed part included
	localparam int TOTAL_BYTES     = 1250;
	localparam int MIN_RANDOM_PKTS = 8;
	localparam int HOLD_CYCLES     = 400;

	// receiver stall styles, one per stretch
	typedef enum logic [1:0] {
		RX_FLOW  = 2'd0,
		RX_LIGHT = 2'd1,
		RX_HEAVY = 2'd2,
		RX_PULSE = 2'd3
	} rx_style_t;

	// predicts the verdict of each packet and holds the ones still due
	class request_verdict_board;
		logic [9:0] byte_count;
		logic [7:0] opcode_high;
		logic       opcode_ok;
		logic       opcode_wr;
		phase_t     phase;
		logic [9:0] name_len;
		logic [3:0] mode_pos;
		// bit0 octet, bit1 netascii still matching
		logic [1:0] mode_hits;
		logic       too_long;

		result_t     due_verdicts[$];
		int unsigned fails;
		int unsigned bytes_seen;
		int unsigned verdicts_seen;
		int unsigned ok_seen;

		function new();
			fails = 0;
			bytes_seen = 0;
			verdicts_seen = 0;
			ok_seen = 0;
			clear();
		endfunction

		function void clear();
			byte_count = '0;
			opcode_high = '0;
			opcode_ok = 1'b0;
			opcode_wr = 1'b0;
			phase = PH_OPCODE;
			name_len = '0;
			mode_pos = '0;
			mode_hits = 2'b11;
			too_long = 1'b0;
		endfunction

		function int pending();
			return due_verdicts.size();
		endfunction

		// one accepted input word
		function void note_byte(logic [7:0] b, logic last);
			logic [7:0] low_b;
			logic       net;
			err_t       err;
			result_t    v;
			bytes_seen++;
			case (phase)
				PH_OPCODE: begin
					if (byte_count == 0) begin
						opcode_high = b;
					end else begin
						opcode_ok = (opcode_high == 8'd0) && (b == OP_READ || b == OP_WRITE);
						opcode_wr = (b == OP_WRITE);
						phase = PH_NAME;
					end
				end
				PH_NAME: begin
					if (b == 8'd0) begin
						phase = PH_MODE;
					end else if (name_len < COUNT_SAT) begin
						name_len++;
					end
				end
				PH_MODE: begin
					if (b == 8'd0) begin
						phase = PH_DONE;
					end else begin
						low_b = (b >= 8'h41 && b <= 8'h5a) ? (b | 8'h20) : b;
						if (mode_pos >= OCTET_LEN) begin
							mode_hits[0] = 1'b0;
						end else if (low_b != OCTET_WORD[mode_pos]) begin
							mode_hits[0] = 1'b0;
						end
						if (mode_pos >= NETASCII_LEN) begin
							mode_hits[1] = 1'b0;
						end else if (low_b != NETASCII_WORD[mode_pos]) begin
							mode_hits[1] = 1'b0;
						end
						if (mode_pos < MODE_POS_MAX) begin
							mode_pos++;
						end
					end
				end
				default: ;
			endcase
			if (byte_count < COUNT_SAT) begin
				byte_count++;
			end
			if (byte_count > MAX_BYTES) begin
				too_long = 1'b1;
			end
			if (!last) begin
				return;
			end

			net = 1'b0;
			err = ERR_NONE;
			if (too_long) begin
				err = ERR_TOO_LONG;
			end else if (byte_count < 2 || !opcode_ok) begin
				err = ERR_NOT_REQ;
			end else if (phase == PH_OPCODE || phase == PH_NAME || name_len == 0 ||
					int'(byte_count) < int'(name_len) + 5) begin
				err = ERR_BAD_NAME;
			end else if (phase == PH_MODE) begin
				err = ERR_BAD_MODE;
			end else if (mode_hits[0] && mode_pos == OCTET_LEN) begin
				net = 1'b0;
			end else if (mode_hits[1] && mode_pos == NETASCII_LEN) begin
				net = 1'b1;
			end else begin
				err = ERR_BAD_MODE;
			end

			if (err == ERR_NONE) begin
				v.request_ok = 1'b1;
				v.is_write = opcode_wr;
				v.transfer_mode = net;
				v.name_length = name_len;
			end else begin
				v.request_ok = 1'b0;
				v.is_write = 1'b0;
				v.transfer_mode = 1'b0;
				v.name_length = '0;
			end
			v.error_kind = err;
			due_verdicts.push_back(v);
			clear();
		endfunction

		// one accepted result word against the oldest verdict due
		function void check_verdict(result_t got);
			result_t exp_v;
			if (due_verdicts.size() == 0) begin
				$error("verdict with no packet behind it: request_ok %0b error_kind %0d",
					got.request_ok, got.error_kind);
				fails++;
				return;
			end
			exp_v = due_verdicts.pop_front();
			verdicts_seen++;
			if (exp_v.request_ok) begin
				ok_seen++;
			end
			if (got.request_ok !== exp_v.request_ok) begin
				$error("request_ok: expected %0b, actual %0b", exp_v.request_ok, got.request_ok);
				fails++;
			end
			if (got.is_write !== exp_v.is_write) begin
				$error("is_write: expected %0b, actual %0b", exp_v.is_write, got.is_write);
				fails++;
			end
			if (got.transfer_mode !== exp_v.transfer_mode) begin
				$error("transfer_mode: expected %0b, actual %0b",
					exp_v.transfer_mode, got.transfer_mode);
				fails++;
			end
			if (got.name_length !== exp_v.name_length) begin
				$error("name_length: expected %0d, actual %0d",
					exp_v.name_length, got.name_length);
				fails++;
			end
			if (got.error_kind !== exp_v.error_kind) begin
				$error("error_kind: expected %0d, actual %0d", exp_v.error_kind, got.error_kind);
				fails++;
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] packet_byte = 8'h00;
	logic       end_of_packet = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       request_ok;
	logic       is_write;
	logic       transfer_mode;
	logic [9:0] name_length;
	logic [2:0] error_kind;

	request_verdict_board board;

	// packet under construction, sent as a whole
	logic [7:0] pkt[$];
	int         burst_left = 0;
	int         bytes_offered = 0;
	// raised once by the stimulus, served by the receiver
	bit         hold_go = 1'b0;

	tftp_request_parser_unit #(
		.MAX_REQUEST_BYTES(MAX_BYTES)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.packet_byte  (packet_byte),
		.end_of_packet(end_of_packet),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.request_ok   (request_ok),
		.is_write     (is_write),
		.transfer_mode(transfer_mode),
		.name_length  (name_length),
		.error_kind   (error_kind)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// both handshakes are sampled here, on values from before the edge
	always @(posedge clk) begin : monitor
		result_t got;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				board.note_byte(packet_byte, end_of_packet);
			end
			if (out_valid && !out_stall) begin
				got.request_ok = request_ok;
				got.is_write = is_write;
				got.transfer_mode = transfer_mode;
				got.name_length = name_length;
				got.error_kind = err_t'(error_kind);
				board.check_verdict(got);
			end
		end
	end

	// offer one word, in bursts with random gaps; returns once it is taken
	task automatic send_word(input logic [7:0] b, input logic last);
		int gap;
		if (burst_left == 0) begin
			// a quarter of the bursts follow on with no gap at all
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		in_valid <= 1'b1;
		packet_byte <= b;
		end_of_packet <= last;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
	endtask

	task automatic send_packet();
		for (int i = 0; i < pkt.size(); i++) begin
			send_word(pkt[i], i == pkt.size() - 1);
		end
		bytes_offered += pkt.size();
		pkt.delete();
	endtask

	// sender goes quiet until every verdict due has come out
	task automatic rest_sender();
		in_valid <= 1'b0;
		burst_left = 0;
		do begin
			@(posedge clk);
		end while (board.pending() != 0);
	endtask

	function automatic void put_opcode(input logic [15:0] op);
		pkt.push_back(op[15:8]);
		pkt.push_back(op[7:0]);
	endfunction

	function automatic void put_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			pkt.push_back(s[i]);
		end
	endfunction

	// random non-zero filename plus its terminator
	function automatic void put_name(input int len);
		for (int i = 0; i < len; i++) begin
			pkt.push_back(8'($urandom_range(1, 255)));
		end
		pkt.push_back(8'h00);
	endfunction

	// mode word in random letter case plus its terminator
	function automatic void put_mode(input logic net);
		logic [7:0] ch;
		for (int i = 0; i < (net ? NETASCII_LEN : OCTET_LEN); i++) begin
			ch = net ? NETASCII_WORD[i] : OCTET_WORD[i];
			if ($urandom_range(0, 1) == 1) begin
				ch = ch & 8'hdf;
			end
			pkt.push_back(ch);
		end
		pkt.push_back(8'h00);
	endfunction

	function automatic void build_request(input logic [15:0] op, input int len, input logic net);
		pkt.delete();
		put_opcode(op);
		put_name(len);
		put_mode(net);
	endfunction

	// receiver: stretches of differing stall styles, plus the one long hold-off
	initial begin : receiver
		rx_style_t style;
		int        span;
		forever begin
			if (hold_go) begin
				hold_go = 1'b0;
				repeat (HOLD_CYCLES) begin
					out_stall <= 1'b1;
					@(posedge clk);
				end
			end
			style = rx_style_t'($urandom_range(0, 3));
			span = $urandom_range(10, 120);
			// a requested hold-off cuts the current stretch short
			for (int k = 0; k < span && !hold_go; k++) begin
				case (style)
					RX_FLOW:  out_stall <= 1'b0;
					RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
					RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
					default:  out_stall <= ((k % 5) < 2);
				endcase
				@(posedge clk);
			end
		end
	end

	initial begin : watchdog
		#400000;
		$display("tftp_request_parser_unit: mismatch");
		$finish;
	end

	initial begin : stimulus
		int          pick;
		int          idx;
		int          cut;
		int          n;
		int          pkt_index;
		logic [15:0] op;

		board = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// shortest read request, octet
		build_request(16'd1, 1, 1'b0);
		send_packet();
		// write request, netascii
		build_request(16'd2, 8, 1'b1);
		send_packet();
		// bytes after the mode terminator are ignored
		build_request(16'd1, 3, 1'b0);
		pkt.push_back(8'hff);
		pkt.push_back(8'h00);
		pkt.push_back(8'h78);
		send_packet();
		// one byte: no opcode at all
		pkt.push_back(8'h00);
		send_packet();
		// opcode alone
		put_opcode(16'd1);
		send_packet();
		// opcode out of range, high byte set, zero
		build_request(16'd3, 4, 1'b0);
		send_packet();
		build_request(16'h0101, 4, 1'b0);
		send_packet();
		build_request(16'd0, 4, 1'b1);
		send_packet();
		// empty filename
		build_request(16'd1, 0, 1'b0);
		send_packet();
		// filename without terminator
		put_opcode(16'd1);
		put_text("abc");
		send_packet();
		// terminated filename but only one byte after it
		put_opcode(16'd1);
		put_name(1);
		put_text("o");
		send_packet();
		// just long enough for the filename, mode left open
		put_opcode(16'd2);
		put_name(1);
		put_text("oc");
		send_packet();
		// mode terminator missing
		build_request(16'd1, 5, 1'b0);
		void'(pkt.pop_back());
		send_packet();
		// near misses on the mode words, the last reaching the saturation point
		put_opcode(16'd1);
		put_name(2);
		put_text("octets");
		pkt.push_back(8'h00);
		send_packet();
		put_opcode(16'd2);
		put_name(2);
		put_text("netasci");
		pkt.push_back(8'h00);
		send_packet();
		put_opcode(16'd1);
		put_name(2);
		put_text("netasciii");
		pkt.push_back(8'h00);
		send_packet();
		// empty mode with a byte after it
		put_opcode(16'd1);
		put_name(1);
		pkt.push_back(8'h00);
		put_text("z");
		send_packet();
		// high-bit byte is not folded like a letter
		put_opcode(16'd1);
		put_name(3);
		put_text("OCTE");
		pkt.push_back(8'hd4);
		pkt.push_back(8'h00);
		send_packet();
		// all upper case
		put_opcode(16'd2);
		put_name(4);
		put_text("NETASCII");
		pkt.push_back(8'h00);
		send_packet();
		// exactly at the size limit
		build_request(16'd1, MAX_BYTES - 9, 1'b0);
		send_packet();
		// one byte over, and too long wins over a bad opcode
		build_request(16'h0305, MAX_BYTES - 8, 1'b0);
		send_packet();

		rest_sender();

		// random part: mostly well-formed requests, some damaged, some noise
		pkt_index = 0;
		while (bytes_offered < TOTAL_BYTES || pkt_index < MIN_RANDOM_PKTS) begin
			pick = $urandom_range(0, 99);
			op = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
				: 16'($urandom_range(1, 2));
			if (pick < 60) begin
				build_request(op, $urandom_range(1, 12), 1'($urandom_range(0, 1)));
				n = $urandom_range(0, 3);
				for (int i = 0; i < n; i++) begin
					pkt.push_back(8'($urandom_range(0, 255)));
				end
			end else if (pick < 75) begin
				// one byte overwritten
				build_request(op, $urandom_range(1, 12), 1'($urandom_range(0, 1)));
				idx = $urandom_range(0, pkt.size() - 1);
				pkt[idx] = 8'($urandom_range(0, 255));
			end else if (pick < 87) begin
				// cut short
				build_request(op, $urandom_range(1, 12), 1'($urandom_range(0, 1)));
				cut = $urandom_range(1, pkt.size());
				while (pkt.size() > cut) begin
					void'(pkt.pop_back());
				end
			end else if (pick < 99) begin
				// noise, often with a plausible opcode in front
				if ($urandom_range(0, 1) == 1) begin
					put_opcode(16'($urandom_range(1, 2)));
				end
				n = $urandom_range(1, 24);
				for (int i = 0; i < n; i++) begin
					pkt.push_back(8'($urandom_range(0, 255)));
				end
			end else begin
				// around the size limit
				build_request(16'($urandom_range(1, 2)), $urandom_range(495, 506),
					1'($urandom_range(0, 1)));
			end
			send_packet();
			pkt_index++;
			// long output hold-off while input keeps coming
			if (pkt_index == 2) begin
				hold_go = 1'b1;
			end
			// input pause until the pipe has drained
			if (pkt_index == 5) begin
				rest_sender();
			end
		end

		rest_sender();
		repeat (12) @(posedge clk);

		$display("covered %0d packet bytes and %0d verdicts, %0d of them good requests",
			board.bytes_seen, board.verdicts_seen, board.ok_seen);
		if (board.fails == 0 && board.pending() == 0) begin
			$display("tftp_request_parser_unit: match");
		end else begin
			$display("tftp_request_parser_unit: mismatch");
		end
		$finish;
	end

endmodule

[files.f]
hdl/tftp_rp_pkg.sv
hdl/tftp_rp_parse.sv
hdl/tftp_rp_out.sv
hdl/tftp_request_parser_unit.sv
dv/tftp_request_parser_unit_test.sv
